/* src/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 (BMP) decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int COUNT_WIDTH = 12;
    localparam int LIMIT_W     = 12;
    localparam int CMP_W       = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam int PADDR_W     = 3;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX     = {COUNT_WIDTH{1'b1}};
    localparam logic [LIMIT_W-1:0]     LIMIT_RESET = 12'hFFF;

    // register index of the configuration port
    localparam logic REG_UNIT_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_TWO     = 2'd1,
        PEND_THREE_A = 2'd2,
        PEND_THREE_B = 2'd3
    } pend_kind_t;

    typedef struct packed {
        pend_kind_t             kind;
        logic [9:0]             partial;
        logic [COUNT_WIDTH-1:0] count;
    } dec_state_t;

    typedef struct packed {
        logic        emit;
        logic [15:0] code_unit;
        logic        is_last;
    } dec_result_t;

endpackage

/* src/u8u16_cfg.sv */
// ----------------------------------------------------------------------------
// u8u16_cfg
// APB-style register port holding the unit limit.
// ----------------------------------------------------------------------------
module u8u16_cfg
    import u8u16_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [LIMIT_W-1:0] unit_limit
);

    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;
    logic               reg_index;

    assign reg_index = paddr[2];
    assign pready    = 1'b1;

    always_comb begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && (reg_index == REG_UNIT_LIMIT)) begin
            limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == REG_UNIT_LIMIT) begin
            prdata = {{(32-LIMIT_W){1'b0}}, limit_reg};
        end
    end

    assign unit_limit = limit_reg;

endmodule

/* src/u8u16_decode.sv */
// ----------------------------------------------------------------------------
// u8u16_decode
// One-byte decode step: next sequence state and the code unit, if any.
// ----------------------------------------------------------------------------
module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic [7:0]         data_byte,
    input  dec_state_t         cur,
    input  logic [LIMIT_W-1:0] unit_limit,
    output dec_state_t         nxt,
    output dec_result_t        res
);

    logic        cont;
    logic [5:0]  low;
    logic        fresh;
    logic        cand;
    logic        room;
    logic [15:0] cp;

    assign cont = (data_byte[7:6] == 2'b10);
    assign low  = data_byte[5:0];
    assign room = (CMP_W'(cur.count) < CMP_W'(unit_limit)) && (cur.count != CNT_MAX);

    always_comb begin
        nxt   = cur;
        fresh = 1'b0;
        cand  = 1'b0;
        cp    = '0;
        res   = '0;
        if (data_byte == 8'd0) begin
            nxt.kind    = PEND_NONE;
            nxt.partial = '0;
            nxt.count   = '0;
            res.emit    = 1'b1;
            res.is_last = 1'b1;
        end else begin
            if (cur.kind != PEND_NONE && cont) begin
                unique case (cur.kind)
                    PEND_THREE_A: begin
                        nxt.kind    = PEND_THREE_B;
                        nxt.partial = {cur.partial[3:0], low};
                    end
                    default: begin
                        // two-byte tail or last byte of a three-byte form
                        nxt.kind    = PEND_NONE;
                        nxt.partial = '0;
                        cand        = 1'b1;
                        cp          = {cur.partial, low};
                    end
                endcase
            end else begin
                // nothing pending, or the lead lost its continuation
                nxt.kind    = PEND_NONE;
                nxt.partial = '0;
                fresh       = 1'b1;
            end

            if (fresh) begin
                priority if (!data_byte[7]) begin
                    cand = 1'b1;
                    cp   = {8'd0, data_byte};
                end else if (data_byte[7:5] == 3'b110) begin
                    nxt.kind    = PEND_TWO;
                    nxt.partial = {5'd0, data_byte[4:0]};
                end else if (data_byte[7:4] == 4'b1110) begin
                    nxt.kind    = PEND_THREE_A;
                    nxt.partial = {6'd0, data_byte[3:0]};
                end else begin
                    // stray continuation, four-byte lead or invalid lead: skipped
                    nxt.kind = PEND_NONE;
                end
            end

            if (cand && room) begin
                res.emit      = 1'b1;
                res.code_unit = cp;
                nxt.count     = cur.count + COUNT_WIDTH'(1);
            end
        end
    end

endmodule

/* src/utf8_to_utf16_bmp_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_bmp_decoder
// Path: s_* byte -> input register -> decode step -> result register -> m_*.
// Throughput: one byte per cycle while m_ready is high; the decode step
// between the input register and the result register is combinational.
// Reset (aresetn low, synchronous): no item held, nothing pending,
// unit count zero, unit_limit back to 4095.
// ----------------------------------------------------------------------------
module utf8_to_utf16_bmp_decoder
    import u8u16_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_code_unit,
    output logic               m_is_last,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [LIMIT_W-1:0] unit_limit;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg, in_byte_next;
    dec_state_t  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_unit_reg, out_unit_next;
    logic        out_last_reg, out_last_next;

    dec_state_t  dec_nxt;
    dec_result_t dec_res;
    logic        advance;

    u8u16_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .unit_limit (unit_limit)
    );

    u8u16_decode u_decode (
        .data_byte  (in_byte_reg),
        .cur        (state_reg),
        .unit_limit (unit_limit),
        .nxt        (dec_nxt),
        .res        (dec_res)
    );

    // the held byte moves on when the result slot is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            in_byte_next  = s_data_byte;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_unit_next  = out_unit_reg;
        out_last_next  = out_last_reg;
        if (advance) begin
            state_next     = dec_nxt;
            out_valid_next = dec_res.emit;
            out_unit_next  = dec_res.code_unit;
            out_last_next  = dec_res.is_last;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg  <= in_byte_next;
        out_unit_reg <= out_unit_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_code_unit = out_unit_reg;
    assign m_is_last   = out_last_reg;

    a_term_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_byte_reg == 8'd0)
        |=> state_reg.kind == PEND_NONE && state_reg.count == '0 && m_valid && m_is_last)
        else $error("terminator did not clear the string state");

    a_last_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_last |-> m_code_unit == 16'd0)
        else $error("terminator carries a nonzero code unit");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (state_reg.count == $past(state_reg.count)
          || state_reg.count == $past(state_reg.count) + COUNT_WIDTH'(1)
          || state_reg.count == '0))
        else $error("unit count moved by more than one");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without a blocked result");

endmodule
